// ===== rtl/reversible_lifo_stack_core_assert.svh =====
// Assertion macros shared by the stack core RTL.
// Depends on nothing; compiles to empty bodies when SYNTHESIS is defined.
`ifndef REVERSIBLE_LIFO_STACK_CORE_ASSERT_SVH
`define REVERSIBLE_LIFO_STACK_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a property while out of reset.
`define RLSC_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Check a property at every edge, reset included.
`define RLSC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RLSC_ASSERT(label, clk, rstn, prop, msg)
`define RLSC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/rlsc_pkg.sv =====
// Shared types and constants for the reversible LIFO stack core.
// Used by reversible_lifo_stack_core; depends on nothing.
package rlsc_pkg;

    localparam int unsigned RLSC_STACK_DEPTH = 16;
    localparam int unsigned WORD_W           = 32;
    localparam int unsigned FILL_W           = 5;
    localparam int unsigned CMD_W            = 2;
    localparam int unsigned STATUS_W         = 2;
    localparam int unsigned S_TDATA_W        = 40;
    localparam int unsigned M_TDATA_W        = 40;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP     = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_REVERSE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RDATA = 7'b0000010,
        S_REV_A = 7'b0000100,
        S_REV_B = 7'b0001000,
        S_REV_C = 7'b0010000,
        S_REV_D = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

endpackage

// ===== rtl/rlsc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; contents are undefined until written.
module rlsc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/reversible_lifo_stack_core.sv =====
// Channel  | Dir | tdata fields, low bit up
// s_axis   | in  | command[1:0], push_value[33:2], zero pad [39:34]
// m_axis   | out | read_value[31:0], status[33:32], fill_level[38:34], zero pad [39]
//
// Push goes straight from accept to S_DONE; pop and peek first pass S_RDATA for
// the registered RAM read. A push refused on a full stack, or a pop or peek
// refused on an empty one, goes straight to S_DONE, as does reverse on n < 2;
// else each pair swap takes two reads and two writes on the single RAM port pair.
// Reset clears the fill count and the control state; the RAM is not cleared.
// A finished result waits in the output register; a stalled m_tready holds the
// block in its final step after the next beat has already been taken.
`include "reversible_lifo_stack_core_assert.svh"

module reversible_lifo_stack_core import rlsc_pkg::*; #(
    parameter int unsigned STACK_DEPTH = RLSC_STACK_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // command[1:0], push_value[33:2]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // read_value[31:0], status[33:32],
                                            // fill_level[38:34]
);

    localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
    localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int unsigned PTR_W  = ADDR_W + 1;

    // Control state
    state_t             state_reg,   state_next;
    logic [CNT_W-1:0]   count_reg,   count_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // Payload state
    logic [ADDR_W-1:0]  lo_reg,      lo_next;
    logic [ADDR_W-1:0]  hi_reg,      hi_next;
    logic [WORD_W-1:0]  held_reg,    held_next;
    logic [WORD_W-1:0]  res_value_reg, res_value_next;
    status_t            res_status_reg, res_status_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // RAM port signals
    logic               ram_wr_en;
    logic [ADDR_W-1:0]  ram_wr_addr;
    logic [WORD_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [ADDR_W-1:0]  ram_rd_addr;
    logic [WORD_W-1:0]  ram_rd_data;

    cmd_t               in_cmd;
    logic [WORD_W-1:0]  in_value;
    logic               s_fire;
    logic               stack_full;
    logic               stack_empty;
    logic               out_free;
    logic               more_pairs;

    rlsc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_entry_ram (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Decode the input beat and stack status
    assign in_cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
    assign in_value    = s_tdata[CMD_W +: WORD_W];
    assign s_tready    = (state_reg == S_IDLE);
    assign s_fire      = s_tvalid && s_tready;
    assign stack_full  = (count_reg == CNT_W'(STACK_DEPTH));
    assign stack_empty = (count_reg == '0);
    assign out_free    = !m_tvalid_reg || m_tready;
    assign more_pairs  = ({1'b0, lo_reg} + PTR_W'(2)) < {1'b0, hi_reg};

    // Sequencer: accept, read, swap pairs, hand off the result
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        m_tvalid_next   = m_tvalid_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        held_next       = held_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_tdata_next    = m_tdata_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = lo_reg;
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = lo_reg;

        // Drop the output beat once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    res_value_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                    case (in_cmd)
                        CMD_PUSH: begin
                            if (stack_full) begin
                                res_status_next = ST_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = count_reg[ADDR_W-1:0];
                                ram_wr_data = in_value;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        CMD_POP, CMD_PEEK: begin
                            if (stack_empty) begin
                                res_value_next  = '1;
                                res_status_next = ST_EMPTY;
                            end else begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = ADDR_W'(count_reg - 1'b1);
                                state_next  = S_RDATA;
                                if (in_cmd == CMD_POP) begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                        end
                        default: begin
                            // Reverse: walk pairs inward when two or more entries
                            if (count_reg > CNT_W'(1)) begin
                                lo_next    = '0;
                                hi_next    = ADDR_W'(count_reg - 1'b1);
                                state_next = S_REV_A;
                            end
                        end
                    endcase
                end
            end
            S_RDATA: begin
                res_value_next = ram_rd_data;
                state_next     = S_DONE;
            end
            S_REV_A: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = lo_reg;
                state_next  = S_REV_B;
            end
            S_REV_B: begin
                // Hold the low entry, fetch the high one
                held_next   = ram_rd_data;
                ram_rd_en   = 1'b1;
                ram_rd_addr = hi_reg;
                state_next  = S_REV_C;
            end
            S_REV_C: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = lo_reg;
                ram_wr_data = ram_rd_data;
                state_next  = S_REV_D;
            end
            S_REV_D: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = hi_reg;
                ram_wr_data = held_reg;
                if (more_pairs) begin
                    lo_next    = lo_reg + 1'b1;
                    hi_next    = hi_reg - 1'b1;
                    state_next = S_REV_A;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Load the output register when it is free
                if (out_free) begin
                    m_tdata_next  = {{(M_TDATA_W - WORD_W - STATUS_W - FILL_W){1'b0}},
                                     FILL_W'(count_reg), res_status_reg, res_value_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        held_reg       <= held_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `RLSC_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(STACK_DEPTH), "fill count above depth")
    `RLSC_ASSERT(a_count_only_on_accept, aclk, aresetn, !s_fire |=> $stable(count_reg), "fill count moved without a beat")
    `RLSC_ASSERT(a_push_grows, aclk, aresetn, (s_fire && in_cmd == CMD_PUSH && !stack_full) |=> count_reg == $past(count_reg) + 1'b1, "push did not grow the stack")
    `RLSC_ASSERT(a_swap_order, aclk, aresetn, (state_reg == S_REV_A || state_reg == S_REV_D) |-> lo_reg < hi_reg, "swap pointers crossed")
    `RLSC_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> (state_reg == S_IDLE && !m_tvalid_reg), "reset did not idle the core")

endmodule

// ===== bench/tb_reversible_lifo_stack_core.sv =====
// Self-checking bench for reversible_lifo_stack_core: directed and random
// command streams against a cycle-free shadow stack. Depends on rlsc_pkg and the core.
module tb_reversible_lifo_stack_core import rlsc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned SETTLE_WAIT  = 80;

    typedef struct packed {
        logic [WORD_W-1:0] read_value;
        status_t           status;
        logic [FILL_W-1:0] fill_level;
    } stack_result_t;

    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_BALANCED
    } traffic_mix_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // command[1:0], push_value[33:2]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // read_value[31:0], status[33:32],
                                          // fill_level[38:34]

    // Shadow copy of the stack contents and the expected results in flight
    logic [WORD_W-1:0]    shadow_entries [RLSC_STACK_DEPTH];
    int unsigned          shadow_fill;
    stack_result_t        pending_results [$];
    int unsigned          error_count;
    int unsigned          cycle_count;

    // Receiver behavior: free-running ready or a stall pattern of its own
    bit                   ready_stalls;
    int unsigned          ready_run;

    reversible_lifo_stack_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Work out the result of one command and advance the shadow stack
    function automatic stack_result_t predict_stack_op(cmd_t cmd, logic [WORD_W-1:0] word);
        stack_result_t     res;
        int                lo;
        int                hi;
        logic [WORD_W-1:0] held;
        res.read_value = '0;
        res.status     = ST_OK;
        case (cmd)
            CMD_PUSH: begin
                if (shadow_fill >= RLSC_STACK_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_entries[shadow_fill] = word;
                    shadow_fill++;
                end
            end
            CMD_POP: begin
                if (shadow_fill == 0) begin
                    res.read_value = '1;
                    res.status     = ST_EMPTY;
                end else begin
                    shadow_fill--;
                    res.read_value = shadow_entries[shadow_fill];
                end
            end
            CMD_PEEK: begin
                if (shadow_fill == 0) begin
                    res.read_value = '1;
                    res.status     = ST_EMPTY;
                end else begin
                    res.read_value = shadow_entries[shadow_fill-1];
                end
            end
            default: begin
                // Swap from both ends inward; an odd middle entry stays put
                lo = 0;
                hi = int'(shadow_fill) - 1;
                while (lo < hi) begin
                    held               = shadow_entries[lo];
                    shadow_entries[lo] = shadow_entries[hi];
                    shadow_entries[hi] = held;
                    lo++;
                    hi--;
                end
            end
        endcase
        res.fill_level = shadow_fill[FILL_W-1:0];
        return res;
    endfunction

    // Present one command beat and hold it until the block takes it
    task automatic send_command(cmd_t cmd, logic [WORD_W-1:0] word);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-CMD_W-WORD_W){1'b0}}, word, cmd};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_stack_op(cmd, word));
    endtask

    task automatic idle_sender(int unsigned cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic drain_results();
        idle_sender(1);
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Pick a word, now and then one of the extremes
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic cmd_t pick_command(traffic_mix_t mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  return (r < 65) ? CMD_PUSH : (r < 80) ? CMD_POP :
                              (r < 92) ? CMD_PEEK : CMD_REVERSE;
            MIX_DRAIN: return (r < 22) ? CMD_PUSH : (r < 75) ? CMD_POP :
                              (r < 88) ? CMD_PEEK : CMD_REVERSE;
            default:   return (r < 40) ? CMD_PUSH : (r < 68) ? CMD_POP :
                              (r < 84) ? CMD_PEEK : CMD_REVERSE;
        endcase
    endfunction

    // Pop, peek and reverse on an empty stack
    task automatic test_empty_stack();
        send_command(CMD_POP, 32'h1234_5678);
        send_command(CMD_PEEK, 32'hFFFF_FFFF);
        send_command(CMD_REVERSE, 32'h0);
    endtask

    // Reverse with an odd count, then with an even count of two
    task automatic test_odd_even_reverse();
        send_command(CMD_PUSH, 32'h7FFF_FFFF);
        send_command(CMD_PUSH, 32'h8000_0000);
        send_command(CMD_PUSH, 32'hFFFF_FFFF);
        send_command(CMD_REVERSE, 32'h0);
        send_command(CMD_PEEK, 32'h0);
        send_command(CMD_POP, 32'h0);
        send_command(CMD_REVERSE, 32'h0);
    endtask

    // Fill to the top, get a push refused, reverse the full stack
    task automatic test_full_stack();
        while (shadow_fill < RLSC_STACK_DEPTH) send_command(CMD_PUSH, pick_word());
        send_command(CMD_PUSH, 32'h5A5A_A5A5);
        send_command(CMD_REVERSE, 32'hFFFF_FFFF);
    endtask

    // Bursty random traffic with phases that fill, drain or mix the stack
    task automatic test_random_traffic(int unsigned items);
        traffic_mix_t mix;
        int unsigned  burst_left;
        bit           no_gaps;
        mix        = MIX_BALANCED;
        burst_left = 0;
        no_gaps    = 1'b0;
        for (int unsigned n = 0; n < items; n++) begin
            if (n % 40 == 0) begin
                mix          = traffic_mix_t'($urandom_range(0, 2));
                no_gaps      = ($urandom_range(0, 3) == 0);
                ready_stalls = ($urandom_range(0, 3) != 0);
            end
            if (n % 150 == 149) drain_results();
            if (burst_left == 0) begin
                if (!no_gaps) idle_sender($urandom_range(0, 6));
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
            send_command(pick_command(mix), pick_word());
        end
    endtask

    // Receiver ready: alternate runs of ready and stall of random length
    always @(negedge aclk) begin
        if (!ready_stalls) begin
            m_tready  <= 1'b1;
            ready_run <= 0;
        end else if (ready_run == 0) begin
            m_tready  <= ~m_tready;
            ready_run <= m_tready ? $urandom_range(1, 8) : $urandom_range(1, 10);
        end else begin
            ready_run <= ready_run - 1;
        end
    end

    // Compare every result beat with the oldest expectation
    always @(posedge aclk) begin
        stack_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none actual %h",
                         $time, m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.read_value) begin
                    error_count++;
                    $display("%0t: read_value expected %h actual %h",
                             $time, want.read_value, m_tdata[31:0]);
                end
                if (m_tdata[33:32] !== want.status) begin
                    error_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, m_tdata[33:32]);
                end
                if (m_tdata[38:34] !== want.fill_level) begin
                    error_count++;
                    $display("%0t: fill_level expected %0d actual %0d",
                             $time, want.fill_level, m_tdata[38:34]);
                end
            end
        end
    end

    // Watchdog on the whole run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        shadow_fill  = 0;
        error_count  = 0;
        cycle_count  = 0;
        ready_stalls = 1'b0;
        ready_run    = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_stack();
        test_odd_even_reverse();
        test_full_stack();
        drain_results();
        test_random_traffic(RANDOM_ITEMS);

        // Let the last results out with the receiver always ready
        idle_sender(1);
        ready_stalls = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_WAIT) @(posedge aclk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
